[hw/rtl/scwa_pkg.sv]
package scwa_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int WEIGHT_BITS = 16;
    localparam int BIG_SPAN    = 5;
    localparam int SMALL_SPAN  = 2;
    localparam int NUM_WEIGHTS = 5;

    localparam int MAX_SPAN    = (BIG_SPAN > SMALL_SPAN) ? BIG_SPAN : SMALL_SPAN;
    localparam int STORE_DEPTH = 2 * MAX_SPAN + 1;
    localparam int BIG_DIV     = 2 * BIG_SPAN + 1;

    localparam int DEPTH_W   = $clog2(STORE_DEPTH);
    localparam int FILL_W    = $clog2(STORE_DEPTH + 1);
    localparam int D_W       = $clog2(MAX_SPAN + 1);
    localparam int TAP_W     = $clog2(2 * MAX_SPAN + 1);
    localparam int WI_W      = $clog2(NUM_WEIGHTS);
    localparam int PROD_BITS = SAMPLE_BITS + WEIGHT_BITS;
    localparam int ACC_BITS  = PROD_BITS + TAP_W;
    localparam int WSUM_BITS = WEIGHT_BITS + $clog2(NUM_WEIGHTS);
    localparam int DIV_BITS  = ACC_BITS + 2;
    localparam int Q_BITS    = SAMPLE_BITS + 2;
    localparam int QSTEP_W   = $clog2(Q_BITS);

    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = WEIGHT_BITS;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_BIG_WINDOW = 3'd0,
        REG_WEIGHT_0   = 3'd1,
        REG_WEIGHT_1   = 3'd2,
        REG_WEIGHT_2   = 3'd3,
        REG_WEIGHT_3   = 3'd4,
        REG_WEIGHT_4   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
        logic                          last_in;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic                          last_out;
        logic                          zero_weight_sum;
    } out_item_t;

    typedef struct packed {
        logic                                    big_window;
        logic [NUM_WEIGHTS-1:0][WEIGHT_BITS-1:0] weight;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
        logic                          last;
        logic                          has_out;
        logic [D_W-1:0]                first_d;
    } job_t;

endpackage

[hw/rtl/scwa_front.sv]
module scwa_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               big_window,
    input  logic               s_valid,
    output logic               s_ready,
    input  scwa_pkg::in_item_t s_data,
    input  logic               q_full,
    output logic               push,
    output scwa_pkg::job_t     push_job
);

    logic [scwa_pkg::FILL_W-1:0] fill_reg;
    logic [scwa_pkg::FILL_W-1:0] fill_inc;
    logic [scwa_pkg::FILL_W-1:0] span_f;
    logic [scwa_pkg::FILL_W-1:0] dmax;

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    // classify: how many results this item releases and where the first centre sits
    always_comb begin
        fill_inc = (fill_reg < scwa_pkg::FILL_W'(scwa_pkg::STORE_DEPTH))
                   ? fill_reg + scwa_pkg::FILL_W'(1) : fill_reg;
        span_f   = big_window ? scwa_pkg::FILL_W'(scwa_pkg::BIG_SPAN)
                              : scwa_pkg::FILL_W'(scwa_pkg::SMALL_SPAN);
        dmax     = fill_inc - scwa_pkg::FILL_W'(1);
        push_job.left  = s_data.left_in;
        push_job.right = s_data.right_in;
        push_job.last  = s_data.last_in;
        if (s_data.last_in) begin
            push_job.has_out = 1'b1;
            push_job.first_d = (dmax > span_f) ? scwa_pkg::D_W'(span_f)
                                               : scwa_pkg::D_W'(dmax);
        end else begin
            push_job.has_out = (fill_inc > span_f);
            push_job.first_d = scwa_pkg::D_W'(span_f);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (push) begin
            fill_reg <= s_data.last_in ? '0 : fill_inc;
        end
    end

endmodule

[hw/rtl/scwa_queue.sv]
module scwa_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  scwa_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output scwa_pkg::job_t pop_job,
    output logic           empty
);

    localparam int PTR_W = (scwa_pkg::QUEUE_DEPTH > 1) ? $clog2(scwa_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(scwa_pkg::QUEUE_DEPTH + 1);

    scwa_pkg::job_t   mem [scwa_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(scwa_pkg::QUEUE_DEPTH));
    assign pop_job = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("queue popped while empty");
    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue pushed while full");
    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");
`endif

endmodule

[hw/rtl/scwa_back.sv]
module scwa_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  scwa_pkg::cfg_t      cfg,
    input  logic                q_empty,
    input  scwa_pkg::job_t      q_job,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output scwa_pkg::out_item_t m_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_MAC,
        S_FLUSH,
        S_DIV_INIT,
        S_DIV,
        S_OUT
    } state_t;

    state_t state_reg;

    logic signed [scwa_pkg::SAMPLE_BITS-1:0] store_l [scwa_pkg::STORE_DEPTH];
    logic signed [scwa_pkg::SAMPLE_BITS-1:0] store_r [scwa_pkg::STORE_DEPTH];

    logic [scwa_pkg::D_W-1:0]              d_reg;
    logic                                  last_reg;
    logic [scwa_pkg::TAP_W-1:0]            k_reg;
    logic signed [scwa_pkg::PROD_BITS-1:0] prod_l_reg;
    logic signed [scwa_pkg::PROD_BITS-1:0] prod_r_reg;
    logic signed [scwa_pkg::ACC_BITS-1:0]  acc_l_reg;
    logic signed [scwa_pkg::ACC_BITS-1:0]  acc_r_reg;
    logic signed [scwa_pkg::WSUM_BITS-1:0] den_reg;
    logic [scwa_pkg::DIV_BITS-1:0]         rem_l_reg;
    logic [scwa_pkg::DIV_BITS-1:0]         rem_r_reg;
    logic [scwa_pkg::DIV_BITS-1:0]         div_reg;
    logic [scwa_pkg::Q_BITS-1:0]           q_l_reg;
    logic [scwa_pkg::Q_BITS-1:0]           q_r_reg;
    logic                                  neg_l_reg;
    logic                                  neg_r_reg;
    logic [scwa_pkg::QSTEP_W-1:0]          step_reg;
    logic                                  zero_reg;
    logic                                  m_valid_reg;
    scwa_pkg::out_item_t                   m_data_reg;

    logic [scwa_pkg::TAP_W-1:0]            k_end;
    logic signed [scwa_pkg::SAMPLE_BITS-1:0] samp_l;
    logic signed [scwa_pkg::SAMPLE_BITS-1:0] samp_r;
    logic signed [scwa_pkg::WEIGHT_BITS-1:0] tap_w;
    logic signed [scwa_pkg::WSUM_BITS-1:0] wsum;
    logic [scwa_pkg::WSUM_BITS-1:0]        den_mag;
    logic [scwa_pkg::ACC_BITS-1:0]         mag_l;
    logic [scwa_pkg::ACC_BITS-1:0]         mag_r;
    logic [scwa_pkg::DIV_BITS-1:0]         num_l;
    logic [scwa_pkg::DIV_BITS-1:0]         num_r;
    logic [scwa_pkg::DIV_BITS-1:0]         div_init;
    logic                                  ge_l;
    logic                                  ge_r;
    logic                                  out_free;

    function automatic logic signed [scwa_pkg::SAMPLE_BITS-1:0] sat_round(
        input logic [scwa_pkg::Q_BITS-1:0] q,
        input logic                        neg
    );
        logic [scwa_pkg::Q_BITS-1:0] lim;
        logic [scwa_pkg::Q_BITS-1:0] neg_q;
        lim   = scwa_pkg::Q_BITS'(1) << (scwa_pkg::SAMPLE_BITS - 1);
        neg_q = '0 - q;
        if (neg) begin
            if (q > lim) begin
                return {1'b1, {(scwa_pkg::SAMPLE_BITS-1){1'b0}}};
            end
            return neg_q[scwa_pkg::SAMPLE_BITS-1:0];
        end
        if (q >= lim) begin
            return {1'b0, {(scwa_pkg::SAMPLE_BITS-1){1'b1}}};
        end
        return q[scwa_pkg::SAMPLE_BITS-1:0];
    endfunction

    assign q_pop    = (state_reg == S_IDLE) && !q_empty;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // tap fetch: window position and weight for the current tap
    always_comb begin
        int span_i;
        int idx_i;
        int wi_i;
        span_i = cfg.big_window ? scwa_pkg::BIG_SPAN : scwa_pkg::SMALL_SPAN;
        k_end  = cfg.big_window ? scwa_pkg::TAP_W'(2 * scwa_pkg::BIG_SPAN)
                                : scwa_pkg::TAP_W'(2 * scwa_pkg::SMALL_SPAN);
        idx_i  = int'(d_reg) + span_i - int'(k_reg);
        wi_i   = int'(k_reg) - scwa_pkg::SMALL_SPAN + 2;
        samp_l = '0;
        samp_r = '0;
        if (idx_i >= 0 && idx_i < scwa_pkg::STORE_DEPTH) begin
            samp_l = store_l[idx_i[scwa_pkg::DEPTH_W-1:0]];
            samp_r = store_r[idx_i[scwa_pkg::DEPTH_W-1:0]];
        end
        tap_w = '0;
        if (cfg.big_window) begin
            tap_w = scwa_pkg::WEIGHT_BITS'(1);
        end else if (wi_i >= 0 && wi_i < scwa_pkg::NUM_WEIGHTS) begin
            tap_w = $signed(cfg.weight[wi_i[scwa_pkg::WI_W-1:0]]);
        end
    end

    always_comb begin
        wsum = '0;
        for (int i = 0; i < scwa_pkg::NUM_WEIGHTS; i++) begin
            wsum = wsum + scwa_pkg::WSUM_BITS'($signed(cfg.weight[i]));
        end
    end

    // rounding divide setup: (2|n| + |d|) / (2|d|)
    always_comb begin
        den_mag  = den_reg[scwa_pkg::WSUM_BITS-1] ? scwa_pkg::WSUM_BITS'(-den_reg)
                                                  : scwa_pkg::WSUM_BITS'(den_reg);
        mag_l    = acc_l_reg[scwa_pkg::ACC_BITS-1] ? scwa_pkg::ACC_BITS'(-acc_l_reg)
                                                   : scwa_pkg::ACC_BITS'(acc_l_reg);
        mag_r    = acc_r_reg[scwa_pkg::ACC_BITS-1] ? scwa_pkg::ACC_BITS'(-acc_r_reg)
                                                   : scwa_pkg::ACC_BITS'(acc_r_reg);
        num_l    = scwa_pkg::DIV_BITS'({mag_l, 1'b0}) + scwa_pkg::DIV_BITS'(den_mag);
        num_r    = scwa_pkg::DIV_BITS'({mag_r, 1'b0}) + scwa_pkg::DIV_BITS'(den_mag);
        div_init = scwa_pkg::DIV_BITS'({den_mag, 1'b0}) << (scwa_pkg::Q_BITS - 1);
        ge_l     = (rem_l_reg >= div_reg);
        ge_r     = (rem_r_reg >= div_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < scwa_pkg::STORE_DEPTH; i++) begin
                store_l[i] <= '0;
                store_r[i] <= '0;
            end
        end else begin
            // result taken; in S_OUT the register is reloaded below instead
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (!q_empty) begin
                        for (int i = scwa_pkg::STORE_DEPTH - 1; i > 0; i--) begin
                            store_l[i] <= store_l[i-1];
                            store_r[i] <= store_r[i-1];
                        end
                        store_l[0] <= q_job.left;
                        store_r[0] <= q_job.right;
                        d_reg      <= q_job.first_d;
                        last_reg   <= q_job.last;
                        if (q_job.has_out) begin
                            state_reg <= S_START;
                        end
                    end
                end
                S_START: begin
                    k_reg      <= '0;
                    acc_l_reg  <= '0;
                    acc_r_reg  <= '0;
                    prod_l_reg <= '0;
                    prod_r_reg <= '0;
                    den_reg    <= cfg.big_window
                                  ? scwa_pkg::WSUM_BITS'(scwa_pkg::BIG_DIV) : wsum;
                    if (!cfg.big_window && wsum == '0) begin
                        zero_reg  <= 1'b1;
                        q_l_reg   <= '0;
                        q_r_reg   <= '0;
                        neg_l_reg <= 1'b0;
                        neg_r_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end else begin
                        zero_reg  <= 1'b0;
                        state_reg <= S_MAC;
                    end
                end
                S_MAC: begin
                    acc_l_reg  <= acc_l_reg + scwa_pkg::ACC_BITS'(prod_l_reg);
                    acc_r_reg  <= acc_r_reg + scwa_pkg::ACC_BITS'(prod_r_reg);
                    prod_l_reg <= samp_l * tap_w;
                    prod_r_reg <= samp_r * tap_w;
                    k_reg      <= k_reg + scwa_pkg::TAP_W'(1);
                    if (k_reg == k_end) begin
                        state_reg <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    acc_l_reg <= acc_l_reg + scwa_pkg::ACC_BITS'(prod_l_reg);
                    acc_r_reg <= acc_r_reg + scwa_pkg::ACC_BITS'(prod_r_reg);
                    state_reg <= S_DIV_INIT;
                end
                S_DIV_INIT: begin
                    rem_l_reg <= num_l;
                    rem_r_reg <= num_r;
                    div_reg   <= div_init;
                    q_l_reg   <= '0;
                    q_r_reg   <= '0;
                    neg_l_reg <= acc_l_reg[scwa_pkg::ACC_BITS-1]
                                 ^ den_reg[scwa_pkg::WSUM_BITS-1];
                    neg_r_reg <= acc_r_reg[scwa_pkg::ACC_BITS-1]
                                 ^ den_reg[scwa_pkg::WSUM_BITS-1];
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    if (ge_l) begin
                        rem_l_reg <= rem_l_reg - div_reg;
                    end
                    if (ge_r) begin
                        rem_r_reg <= rem_r_reg - div_reg;
                    end
                    q_l_reg  <= {q_l_reg[scwa_pkg::Q_BITS-2:0], ge_l};
                    q_r_reg  <= {q_r_reg[scwa_pkg::Q_BITS-2:0], ge_r};
                    div_reg  <= div_reg >> 1;
                    step_reg <= step_reg + scwa_pkg::QSTEP_W'(1);
                    if (step_reg == scwa_pkg::QSTEP_W'(scwa_pkg::Q_BITS - 1)) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        m_valid_reg                <= 1'b1;
                        m_data_reg.left_out        <= sat_round(q_l_reg, neg_l_reg);
                        m_data_reg.right_out       <= sat_round(q_r_reg, neg_r_reg);
                        m_data_reg.last_out        <= last_reg && (d_reg == '0);
                        m_data_reg.zero_weight_sum <= zero_reg;
                        if (!last_reg || d_reg == '0) begin
                            if (last_reg) begin
                                for (int i = 0; i < scwa_pkg::STORE_DEPTH; i++) begin
                                    store_l[i] <= '0;
                                    store_r[i] <= '0;
                                end
                            end
                            state_reg <= S_IDLE;
                        end else begin
                            d_reg     <= d_reg - scwa_pkg::D_W'(1);
                            state_reg <= S_START;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_divisor_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (div_reg != '0))
        else $error("divider running with a zero divisor");
    a_centre_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (int'(d_reg) <= scwa_pkg::MAX_SPAN))
        else $error("window centre beyond span");
    a_buffer_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_OUT && out_free && last_reg && d_reg == '0)
        |=> (state_reg == S_IDLE && store_l[0] == '0 && store_r[0] == '0))
        else $error("window not cleared after final item of buffer");
`endif

endmodule

[hw/rtl/stereo_centered_window_average.sv]
// channel  ports                          dir  payload
// input    s_valid s_ready s_data         in   in_item_t: left_in, right_in, last_in
// result   m_valid m_ready m_data         out  out_item_t: left_out, right_out,
//                                              last_out, zero_weight_sum
// config   cfg_wr_en cfg_addr cfg_wdata   in   index 0 big_window, 1..5 weight_0..4
//
// the back end takes one item at a time; each result an item releases walks
// 11 taps in big mode or 5 in small mode through one multiply-accumulate per
// channel, then an 18-step restoring divider; a result with a zero weight
// sum skips both; a final item releases up to 6 results; reset is synchronous
// on aresetn low and clears the window store, the configuration and the
// control state; the 2-entry job queue takes items while the back end works
// and the output register holds a result while m_ready is low
module stereo_centered_window_average (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  scwa_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output scwa_pkg::out_item_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [scwa_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [scwa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // configuration registers
    scwa_pkg::cfg_t cfg_reg;

    // front end to queue
    logic           push;
    scwa_pkg::job_t push_job;
    logic           q_full;

    // queue to back end
    logic           q_pop;
    logic           q_empty;
    scwa_pkg::job_t q_job;

    // register writes, indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                scwa_pkg::REG_BIG_WINDOW: cfg_reg.big_window <= cfg_wdata[0];
                scwa_pkg::REG_WEIGHT_0:   cfg_reg.weight[0]  <= cfg_wdata;
                scwa_pkg::REG_WEIGHT_1:   cfg_reg.weight[1]  <= cfg_wdata;
                scwa_pkg::REG_WEIGHT_2:   cfg_reg.weight[2]  <= cfg_wdata;
                scwa_pkg::REG_WEIGHT_3:   cfg_reg.weight[3]  <= cfg_wdata;
                scwa_pkg::REG_WEIGHT_4:   cfg_reg.weight[4]  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // front end: tracks buffer fill and tags each item with its result count
    scwa_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .big_window (cfg_reg.big_window),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job)
    );

    // short job queue so input and compute stall independently
    scwa_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (q_job),
        .empty    (q_empty)
    );

    // back end: window store, shared mac, divider, output register
    scwa_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_job   (q_job),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[tb/sv/window_average_checker.sv]
module window_average_checker
    import scwa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  in_item_t              s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  out_item_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatch_count,
    output int                    backlog
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint SAT_LO = -SAT_HI - 1;
    localparam int     W_HALF = NUM_WEIGHTS / 2;

    logic                          mode_big;
    logic signed [WEIGHT_BITS-1:0] tap_weight [NUM_WEIGHTS];
    logic signed [SAMPLE_BITS-1:0] hist_l [STORE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] hist_r [STORE_DEPTH];
    int                            taken;
    out_item_t                     smoothed_q [$];

    // nearest, ties away from zero
    function automatic longint round_div(longint num, longint den);
        longint n;
        longint d;
        longint q;
        bit     neg;
        neg = (num < 0) != (den < 0);
        n   = (num < 0) ? -num : num;
        d   = (den < 0) ? -den : den;
        q   = (2 * n + d) / (2 * d);
        return neg ? -q : q;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(longint v);
        longint c;
        c = v;
        if (c > SAT_HI) c = SAT_HI;
        if (c < SAT_LO) c = SAT_LO;
        return c[SAMPLE_BITS-1:0];
    endfunction

    // centre at history index d, index grows with age
    function automatic out_item_t centered_result(int d);
        int        span;
        int        j;
        int        idx;
        int        k;
        longint    acc_l;
        longint    acc_r;
        longint    wsum;
        longint    sl;
        longint    sr;
        longint    w;
        out_item_t r;
        span  = mode_big ? BIG_SPAN : SMALL_SPAN;
        r     = '0;
        acc_l = 0;
        acc_r = 0;
        wsum  = 0;
        if (!mode_big) begin
            for (k = 0; k < NUM_WEIGHTS; k++) wsum += tap_weight[k];
        end
        for (j = -span; j <= span; j++) begin
            idx = d - j;
            sl  = 0;
            sr  = 0;
            w   = 0;
            if (idx >= 0 && idx < STORE_DEPTH) begin
                sl = hist_l[idx];
                sr = hist_r[idx];
            end
            if (mode_big) begin
                acc_l += sl;
                acc_r += sr;
            end else begin
                if (j >= -W_HALF && j <= W_HALF) w = tap_weight[j + W_HALF];
                acc_l += sl * w;
                acc_r += sr * w;
            end
        end
        if (mode_big) begin
            r.left_out  = clamp_sample(round_div(acc_l, BIG_DIV));
            r.right_out = clamp_sample(round_div(acc_r, BIG_DIV));
        end else if (wsum == 0) begin
            r.zero_weight_sum = 1'b1;
        end else begin
            r.left_out  = clamp_sample(round_div(acc_l, wsum));
            r.right_out = clamp_sample(round_div(acc_r, wsum));
        end
        return r;
    endfunction

    function automatic void clear_history();
        int i;
        for (i = 0; i < STORE_DEPTH; i++) begin
            hist_l[i] = '0;
            hist_r[i] = '0;
        end
        taken = 0;
    endfunction

    function automatic void absorb_sample(in_item_t it);
        int        span;
        int        i;
        int        d;
        out_item_t r;
        span = mode_big ? BIG_SPAN : SMALL_SPAN;
        for (i = STORE_DEPTH - 1; i > 0; i--) begin
            hist_l[i] = hist_l[i - 1];
            hist_r[i] = hist_r[i - 1];
        end
        hist_l[0] = it.left_in;
        hist_r[0] = it.right_in;
        if (taken < STORE_DEPTH) taken++;
        if (!it.last_in) begin
            if (taken > span) smoothed_q.push_back(centered_result(span));
        end else begin
            // flush every pending centre, oldest first
            d = (taken - 1 > span) ? span : taken - 1;
            for (; d >= 0; d--) begin
                r          = centered_result(d);
                r.last_out = (d == 0);
                smoothed_q.push_back(r);
            end
            clear_history();
        end
    endfunction

    function automatic void compare_field(string name, logic signed [SAMPLE_BITS-1:0] want,
                                          logic signed [SAMPLE_BITS-1:0] got);
        if (got !== want) begin
            $error("%s expected %0d actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        int        k;
        if (!aresetn) begin
            mode_big = 1'b0;
            for (k = 0; k < NUM_WEIGHTS; k++) tap_weight[k] = '0;
            clear_history();
            smoothed_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_BIG_WINDOW: mode_big      = cfg_wdata[0];
                    REG_WEIGHT_0:   tap_weight[0] = cfg_wdata;
                    REG_WEIGHT_1:   tap_weight[1] = cfg_wdata;
                    REG_WEIGHT_2:   tap_weight[2] = cfg_wdata;
                    REG_WEIGHT_3:   tap_weight[3] = cfg_wdata;
                    REG_WEIGHT_4:   tap_weight[4] = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (smoothed_q.size() == 0) begin
                    $error("unexpected result item left_out %0d right_out %0d",
                           m_data.left_out, m_data.right_out);
                    mismatch_count++;
                end else begin
                    want = smoothed_q.pop_front();
                    compare_field("left_out", want.left_out, m_data.left_out);
                    compare_field("right_out", want.right_out, m_data.right_out);
                    compare_field("last_out", SAMPLE_BITS'(want.last_out),
                                  SAMPLE_BITS'(m_data.last_out));
                    compare_field("zero_weight_sum", SAMPLE_BITS'(want.zero_weight_sum),
                                  SAMPLE_BITS'(m_data.zero_weight_sum));
                end
            end
            if (s_valid && s_ready) absorb_sample(s_data);
        end
        backlog <= smoothed_q.size();
    end

endmodule

[tb/sv/stereo_centered_window_average_tb.sv]
module stereo_centered_window_average_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import scwa_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 9;
    // covers the longest flush of 6 results, plus queue and margin
    localparam int SETTLE_CYCLES = 250;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 45;

    // addresses past the register map, the block must ignore them
    localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR_A = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR_B = 3'd7;

    localparam logic [SAMPLE_BITS-1:0] S_MAX = 16'h7fff;
    localparam logic [SAMPLE_BITS-1:0] S_MIN = 16'h8000;
    localparam logic [WEIGHT_BITS-1:0] W_ONE = 16'h0100;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    in_item_t              s_data    = '0;
    logic                  m_ready   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_ready;
    logic                  m_valid;
    out_item_t             m_data;

    int mismatch_count;
    int backlog;
    int idle_cycles = 0;
    bit gaps_on     = 1'b1;
    bit hold_req    = 1'b0;

    always #(CLK_HALF) aclk = ~aclk;

    stereo_centered_window_average u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    window_average_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .backlog        (backlog)
    );

    // watchdog: too long without any item moving on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: random back-pressure bursts, plus one long hold on request
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            if (hold_req && !held) begin
                // long hold, the block fills up and has to stall its input
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    function automatic in_item_t make_item(logic [SAMPLE_BITS-1:0] l,
                                           logic [SAMPLE_BITS-1:0] r, logic last);
        in_item_t it;
        it.left_in  = l;
        it.right_in = r;
        it.last_in  = last;
        return it;
    endfunction

    // extremes and values near zero get a fair share, the rest is uniform
    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return SAMPLE_BITS'($urandom_range(0, 3)) - 16'd1;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // kind 0: near unity taps, 1: anything, 2: zero sum, 3: rails only
    function automatic logic [NUM_WEIGHTS-1:0][WEIGHT_BITS-1:0] pick_weights(int kind);
        logic [NUM_WEIGHTS-1:0][WEIGHT_BITS-1:0] w;
        int                                      k;
        int                                      sum;
        sum = 0;
        for (k = 0; k < NUM_WEIGHTS; k++) begin
            case (kind)
                0:       w[k] = WEIGHT_BITS'($urandom_range(0, 640) - 128);
                1:       w[k] = WEIGHT_BITS'($urandom);
                2:       w[k] = WEIGHT_BITS'($urandom_range(0, 8000) - 4000);
                default: w[k] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            endcase
            if (k < NUM_WEIGHTS - 1) sum += $signed(w[k]);
        end
        if (kind == 2) w[NUM_WEIGHTS-1] = WEIGHT_BITS'(-sum);
        return w;
    endfunction

    // offer one item, optionally after a gap, and wait for the handshake
    task automatic push_sample(input in_item_t it);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    // all six registers, then the two spare addresses with junk
    task automatic write_config(input logic big,
                                input logic [NUM_WEIGHTS-1:0][WEIGHT_BITS-1:0] w);
        int k;
        cfg_wr_en <= 1'b1;
        cfg_addr  <= REG_BIG_WINDOW;
        // upper bits of the mode word are don't-care
        cfg_wdata <= {(CFG_DATA_W-1)'($urandom), big};
        @(posedge aclk);
        for (k = 0; k < NUM_WEIGHTS; k++) begin
            cfg_addr  <= cfg_reg_t'(REG_WEIGHT_0 + k);
            cfg_wdata <= w[k];
            @(posedge aclk);
        end
        cfg_addr  <= UNMAPPED_ADDR_A;
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge aclk);
        cfg_addr  <= UNMAPPED_ADDR_B;
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // wait for every expected result, then let in-flight work settle
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (backlog != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // buffers of random length, mostly short, now and then longer than the store
    task automatic random_phase(input int n_items);
        int       k;
        int       remaining;
        in_item_t it;
        remaining = 0;
        for (k = 0; k < n_items; k++) begin
            if (remaining == 0) begin
                remaining = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30)
                                                        : $urandom_range(1, 14);
            end
            remaining--;
            it = make_item(pick_sample(), pick_sample(),
                           (remaining == 0) || (k == n_items - 1));
            if (it.last_in) remaining = 0;
            push_sample(it);
        end
    endtask

    initial begin
        int phase;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // weighted mode, unity taps, rails on both channels
        write_config(1'b0, {5{W_ONE}});
        push_sample(make_item(S_MAX, S_MIN, 1'b0));
        push_sample(make_item(S_MIN, S_MAX, 1'b0));
        push_sample(make_item(16'h0000, 16'h0000, 1'b0));
        push_sample(make_item(16'h0001, 16'hffff, 1'b0));
        push_sample(make_item(S_MAX, S_MAX, 1'b1));
        // buffer of a single sample
        push_sample(make_item(S_MIN, S_MIN, 1'b1));
        drain();

        // weights that cancel, results forced to zero with the flag
        write_config(1'b0, {16'hfe00, 16'h0200, 16'h0000, 16'hff00, W_ONE});
        push_sample(make_item(S_MAX, 16'h1234, 1'b0));
        push_sample(make_item(S_MIN, 16'h4321, 1'b0));
        push_sample(make_item(16'h00ff, S_MAX, 1'b1));
        drain();

        // plain mean, weights at their rails must not matter
        write_config(1'b1, {16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
        repeat (5) push_sample(make_item(S_MIN, S_MAX, 1'b0));
        // six in the store, the flush releases the most results
        push_sample(make_item(S_MIN, S_MAX, 1'b1));
        drain();

        // tiny weight sum, quotient saturates
        write_config(1'b0, {16'h0000, 16'h0000, 16'h8002, 16'h0000, 16'h7fff});
        push_sample(make_item(S_MAX, S_MIN, 1'b0));
        push_sample(make_item(S_MAX, S_MIN, 1'b0));
        push_sample(make_item(16'h1234, 16'hedcb, 1'b0));
        push_sample(make_item(S_MAX, S_MIN, 1'b1));
        drain();

        // mode switch in the middle of a buffer
        write_config(1'b1, {5{W_ONE}});
        push_sample(make_item(S_MAX, S_MAX, 1'b0));
        push_sample(make_item(S_MIN, S_MIN, 1'b0));
        push_sample(make_item(16'h0100, 16'hff00, 1'b0));
        drain();
        write_config(1'b0, {5{W_ONE}});
        push_sample(make_item(16'h2000, 16'he000, 1'b0));
        push_sample(make_item(S_MAX, S_MIN, 1'b0));
        push_sample(make_item(16'h0003, 16'hfffd, 1'b1));
        drain();

        // random phases, each with its own setting
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            gaps_on = (phase < RANDOM_PHASES - 2) ? ($urandom_range(0, 3) != 0) : 1'b0;
            if (phase == 1) begin
                gaps_on  = 1'b1;
                hold_req = 1'b1;
            end
            write_config(phase % 3 == 2, pick_weights(phase % 4));
            random_phase(PHASE_ITEMS);
            drain();
        end

        if (mismatch_count == 0 && backlog == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
